[hw/rtl/czn_pkg.sv]
package czn_pkg;

  // default sizes of the sample store
  localparam int MAX_ROWS_DEF = 1024;
  localparam int MAX_COLS_DEF = 128;

  // configuration port
  localparam int  CFG_PADDR_W     = 3;
  localparam logic CFG_IDX_COLUMNS = 1'b0;
  localparam logic [7:0] COLUMNS_RST = 8'd1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_DEV  = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_NO_STATS  = 3'd4
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] sample;
    logic [9:0]         row_index;
    logic [6:0]         col_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic scan;
    logic sq;
    logic acc_clr;
    logic div_mean;
    logic div_var;
    logic div_z;
    logic mean_ld;
    logic sqrt_go;
    logic col_store;
    logic fin_z;
    logic fin_dev0;
    logic fin_comp;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic imm;
    logic row_last;
    logic col_last;
    logic pipe_busy;
    logic div_busy;
    logic div_done;
    logic sqrt_done;
    logic dev_zero;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/czn_ram.sv]
module czn_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] addr,
  input  logic [W-1:0]                         wdata,
  output logic [W-1:0]                         rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
endmodule

[hw/rtl/czn_div.sv]
module czn_div #(
  parameter int DW = 74,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CNT_W = $clog2(DW);

  logic [DW-1:0]    quo_r;
  logic [VW:0]      rem_r;
  logic [VW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [VW:0]      rem_sh;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r[VW-1:0], quo_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;
endmodule

[hw/rtl/czn_ctrl.sv]
module czn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  czn_pkg::sts_t sts,
  output czn_pkg::cmd_t cmd
);
  import czn_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_RWAIT = 10'b00_0000_0010,
    S_RDIV  = 10'b00_0000_0100,
    S_P1    = 10'b00_0000_1000,
    S_P1D   = 10'b00_0001_0000,
    S_MDIV  = 10'b00_0010_0000,
    S_P2    = 10'b00_0100_0000,
    S_P2D   = 10'b00_1000_0000,
    S_VDIV  = 10'b01_0000_0000,
    S_SQRT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE) && sts.out_free;
    cmd.sq    = (state_r == S_P2) || (state_r == S_P2D);
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (!sts.imm) begin
            if (sts.op == OP_COMPUTE) begin
              cmd.acc_clr = 1'b1;
              state_nxt   = S_P1;
            end else if (sts.op == OP_READ) begin
              state_nxt = S_RWAIT;
            end
          end
        end
      end
      // element and column stats arrive from memory
      S_RWAIT: begin
        if (sts.dev_zero) begin
          cmd.fin_dev0 = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.div_z = 1'b1;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        if (sts.div_done) begin
          cmd.fin_z = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // pass one: column sum
      S_P1: begin
        cmd.scan = 1'b1;
        if (sts.row_last) begin
          state_nxt = S_P1D;
        end
      end
      S_P1D: begin
        if (!sts.pipe_busy) begin
          cmd.div_mean = 1'b1;
          state_nxt    = S_MDIV;
        end
      end
      S_MDIV: begin
        if (sts.div_done) begin
          cmd.mean_ld = 1'b1;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_P2;
        end
      end
      // pass two: sum of squared differences
      S_P2: begin
        cmd.scan = 1'b1;
        if (sts.row_last) begin
          state_nxt = S_P2D;
        end
      end
      S_P2D: begin
        if (!sts.pipe_busy) begin
          cmd.div_var = 1'b1;
          state_nxt   = S_VDIV;
        end
      end
      S_VDIV: begin
        if (sts.div_done) begin
          cmd.sqrt_go = 1'b1;
          state_nxt   = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.col_store = 1'b1;
          cmd.acc_clr   = 1'b1;
          if (sts.col_last) begin
            cmd.fin_comp = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_P1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

[hw/rtl/czn_dp.sv]
module czn_dp #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  czn_pkg::cmd_t      cmd,
  output czn_pkg::sts_t      sts,
  input  czn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output czn_pkg::out_item_t out_data,
  input  logic [7:0]         cfg_columns,
  input  logic               cfg_wr
);
  import czn_pkg::*;

  localparam int RC_W   = $clog2(MAX_ROWS + 1);
  localparam int RI_W   = $clog2(MAX_ROWS);
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW     = ($clog2(MAX_COLS + 1) > 8) ? $clog2(MAX_COLS + 1) : 8;
  localparam int RW     = (RC_W > 10) ? RC_W : 10;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = 32 + $clog2(MAX_ROWS);
  localparam int DW     = 64 + $clog2(MAX_ROWS);

  // effective column count, clamped to 1..MAX_COLS
  logic [CW-1:0] cfg_ext, cols;
  assign cfg_ext = CW'(cfg_columns);
  assign cols    = (cfg_columns == 8'd0) ? CW'(1) :
                   (cfg_ext > CW'(MAX_COLS)) ? CW'(MAX_COLS) : cfg_ext;

  logic [RC_W-1:0]  rc_r;
  logic [COL_W-1:0] lc_r;
  logic             stats_r;

  // load bookkeeping
  logic             lc_ge, full, wrap;
  logic [RC_W-1:0]  rc_a, rc_b;
  logic [COL_W-1:0] lc_a, lc_b;
  logic [CW-1:0]    lc_inc;
  logic [ADDR_W-1:0] load_addr, rd_addr, scan_addr;

  assign lc_ge  = CW'(lc_r) >= cols;
  assign rc_a   = (lc_ge && (rc_r < RC_W'(MAX_ROWS))) ? rc_r + RC_W'(1) : rc_r;
  assign lc_a   = lc_ge ? '0 : lc_r;
  assign full   = rc_a == RC_W'(MAX_ROWS);
  assign lc_inc = CW'(lc_a) + CW'(1);
  assign wrap   = lc_inc >= cols;
  assign rc_b   = wrap ? rc_a + RC_W'(1) : rc_a;
  assign lc_b   = wrap ? '0 : lc_inc[COL_W-1:0];
  assign load_addr = ADDR_W'(rc_a) * ADDR_W'(MAX_COLS) + ADDR_W'(lc_a);

  // read range check
  logic rd_bad;
  assign rd_bad  = (RW'(in_data.row_index) >= RW'(rc_r)) || (CW'(in_data.col_index) >= cols);
  assign rd_addr = ADDR_W'(in_data.row_index) * ADDR_W'(MAX_COLS) + ADDR_W'(in_data.col_index);

  // immediate answers
  logic    imm;
  status_t imm_st;
  always_comb begin
    imm    = 1'b1;
    imm_st = ST_OK;
    case (in_data.op)
      OP_LOAD:    imm_st = full ? ST_FULL : ST_OK;
      OP_COMPUTE: begin
        imm    = rc_r == '0;
        imm_st = ST_NO_STATS;
      end
      OP_READ: begin
        imm    = !stats_r || rd_bad;
        imm_st = !stats_r ? ST_NO_STATS : ST_BAD_INDEX;
      end
      OP_CLEAR:   imm_st = ST_OK;
      default:    imm_st = ST_OK;
    endcase
  end

  // scan iterators
  logic [RI_W-1:0]  row_it_r;
  logic [COL_W-1:0] col_it_r;
  logic             row_last, col_last;
  assign row_last  = RC_W'(row_it_r) == (rc_r - RC_W'(1));
  assign col_last  = CW'(col_it_r) == (cols - CW'(1));
  assign scan_addr = ADDR_W'(row_it_r) * ADDR_W'(MAX_COLS) + ADDR_W'(col_it_r);

  // sample store and column stats memories
  logic              st_we;
  logic [ADDR_W-1:0] st_addr;
  logic [31:0]       st_dout;
  logic [COL_W-1:0]  md_addr;
  logic [63:0]       md_dout;
  logic [31:0]       mean_r;
  logic [31:0]       sroot_r;

  assign st_we   = cmd.take && (in_data.op == OP_LOAD) && !full;
  assign st_addr = st_we ? load_addr : (cmd.take ? rd_addr : scan_addr);
  assign md_addr = cmd.col_store ? col_it_r : COL_W'(in_data.col_index);

  czn_ram #(.W(32), .D(DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (in_data.sample),
    .rdata (st_dout)
  );

  czn_ram #(.W(64), .D(MAX_COLS)) u_stats (
    .clk   (clk),
    .we    (cmd.col_store),
    .addr  (md_addr),
    .wdata ({sroot_r, mean_r}),
    .rdata (md_dout)
  );

  // differences and magnitudes
  logic [32:0] d_scan, d_rd;
  logic [31:0] mag_scan, mag_rd;
  always_comb begin
    d_scan   = {st_dout[31], st_dout} - {mean_r[31], mean_r};
    d_rd     = {st_dout[31], st_dout} - {md_dout[31], md_dout[31:0]};
    mag_scan = d_scan[32] ? 32'(-d_scan) : d_scan[31:0];
    mag_rd   = d_rd[32] ? 32'(-d_rd) : d_rd[31:0];
  end

  // scan pipeline: read, then accumulate the sum (pass one) or square and accumulate (pass two)
  logic             vld1_r, vld2_r;
  logic [63:0]      sq_r;
  logic [SUM_W-1:0] sum_r;
  logic [DW-1:0]    sq_acc_r;
  logic [SUM_W-1:0] sum_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= cmd.scan;
      vld2_r <= vld1_r && cmd.sq;
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= mag_scan * mag_scan;
    if (cmd.acc_clr) begin
      sum_r    <= '0;
      sq_acc_r <= '0;
    end else begin
      if (vld1_r && !cmd.sq) begin
        sum_r <= sum_r + {{(SUM_W-32){st_dout[31]}}, st_dout};
      end
      if (vld2_r) begin
        sq_acc_r <= sq_acc_r + DW'(sq_r);
      end
    end
  end

  assign sum_abs = sum_r[SUM_W-1] ? -sum_r : sum_r;

  // shared divider
  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_a, q;
  logic [31:0]   div_b;
  logic          neg_r;

  assign div_start = cmd.div_mean || cmd.div_var || cmd.div_z;
  assign div_a = cmd.div_mean ? DW'(sum_abs) :
                 cmd.div_var  ? sq_acc_r : DW'({mag_rd, 16'd0});
  assign div_b = cmd.div_z ? md_dout[63:32] : 32'(rc_r);

  czn_div #(.DW(DW), .VW(32)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_mean) begin
      neg_r <= sum_r[SUM_W-1];
    end else if (cmd.div_z) begin
      neg_r <= d_rd[32];
    end
    if (cmd.mean_ld) begin
      mean_r <= neg_r ? -q[31:0] : q[31:0];
    end
  end

  // integer square root, two radicand bits per cycle
  logic [63:0] rad_r;
  logic [34:0] srem_r, srem_sh, trial;
  logic [4:0]  scnt_r;
  logic        sbusy_r, sdone_r, sge;

  assign srem_sh = {srem_r[32:0], rad_r[63:62]};
  assign trial   = {1'b0, sroot_r, 2'b01};
  assign sge     = srem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
      sdone_r <= 1'b0;
      scnt_r  <= '0;
    end else begin
      sdone_r <= 1'b0;
      if (cmd.sqrt_go) begin
        sbusy_r <= 1'b1;
        scnt_r  <= '0;
      end else if (sbusy_r) begin
        scnt_r <= scnt_r + 5'd1;
        if (scnt_r == 5'd31) begin
          sbusy_r <= 1'b0;
          sdone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_go) begin
      rad_r   <= q[63:0];
      srem_r  <= '0;
      sroot_r <= '0;
    end else if (sbusy_r) begin
      rad_r   <= {rad_r[61:0], 2'b00};
      srem_r  <= sge ? (srem_sh - trial) : srem_sh;
      sroot_r <= {sroot_r[30:0], sge};
    end
  end

  // z-score saturation
  logic [31:0] zval;
  always_comb begin
    if (!neg_r) begin
      zval = (|q[DW-1:31]) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      zval = ((|q[DW-1:32]) || (q[31] && (|q[30:0]))) ? 32'h8000_0000 : -q[31:0];
    end
  end

  // matrix bookkeeping and iterators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r     <= '0;
      lc_r     <= '0;
      stats_r  <= 1'b0;
      row_it_r <= '0;
      col_it_r <= '0;
    end else begin
      if (cmd.take) begin
        case (in_data.op)
          OP_LOAD: begin
            if (full) begin
              rc_r <= rc_a;
              lc_r <= lc_a;
            end else begin
              rc_r    <= rc_b;
              lc_r    <= lc_b;
              stats_r <= 1'b0;
            end
          end
          OP_COMPUTE: begin
            if (rc_r == '0) begin
              stats_r <= 1'b0;
            end
          end
          OP_CLEAR: begin
            rc_r    <= '0;
            lc_r    <= '0;
            stats_r <= 1'b0;
          end
          default: ;
        endcase
        col_it_r <= '0;
      end
      if (cmd.scan) begin
        row_it_r <= row_last ? '0 : row_it_r + RI_W'(1);
      end
      if (cmd.col_store) begin
        col_it_r <= col_it_r + COL_W'(1);
      end
      if (cmd.fin_comp) begin
        stats_r <= 1'b1;
      end
      if (cfg_wr) begin
        stats_r <= 1'b0;
      end
    end
  end

  // result register
  logic      out_valid_r, out_ld;
  out_item_t out_r;
  assign out_ld = (cmd.take && imm) || cmd.fin_z || cmd.fin_dev0 || cmd.fin_comp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_r.value  <= cmd.fin_z ? zval : 32'd0;
      out_r.status <= cmd.take ? imm_st : (cmd.fin_dev0 ? ST_ZERO_DEV : ST_OK);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts           = '0;
    sts.op        = in_data.op;
    sts.imm       = imm;
    sts.row_last  = row_last;
    sts.col_last  = col_last;
    sts.pipe_busy = vld1_r || vld2_r;
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.sqrt_done = sdone_r;
    sts.dev_zero  = md_dout[63:32] == 32'd0;
    sts.out_free  = !out_valid_r || out_ready;
  end
endmodule

[hw/rtl/column_zscore_normalizer.sv]
// Column z-score normalizer. Samples (signed Q16.16) are loaded one beat at a
// time in row-major order, columns_in_use per row; a compute command then
// finds each column's mean and population deviation, and a read returns the
// z-score of one stored element, saturated Q16.16. Every command gives one
// result beat. Load, clear and any rejected command are answered immediately. A
// read waits on the bit-serial divider, whose dividend is DW = 64 +
// clog2(MAX_ROWS) bits wide (74 by default). Compute runs per column a sum
// pass and a squares pass over the single-port sample memory, with a
// division after each and then a square root. The sample memory needs no
// clearing pass; the block is ready out of reset.
module column_zscore_normalizer #(
  parameter int MAX_ROWS = czn_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = czn_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  czn_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output czn_pkg::out_item_t               out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [czn_pkg::CFG_PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import czn_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_wr;
  logic [7:0] cfg_columns_r;

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == CFG_IDX_COLUMNS);
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_COLUMNS) ? {24'd0, cfg_columns_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_columns_r <= COLUMNS_RST;
    end else if (cfg_wr) begin
      cfg_columns_r <= cfg_pwdata[7:0];
    end
  end

  czn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  czn_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_columns (cfg_columns_r),
    .cfg_wr      (cfg_wr)
  );

  // a new beat is only taken when the result slot frees up
  a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while result slot busy");

  // one result source per cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.fin_z, cmd.fin_dev0, cmd.fin_comp}))
    else $error("multiple result sources");

  // divider is never restarted mid-operation
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_mean || cmd.div_var || cmd.div_z) |-> !sts.div_busy)
    else $error("divider started while busy");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import czn_pkg::*;

  localparam int NROWS = MAX_ROWS_DEF;
  localparam int NCOLS = MAX_COLS_DEF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_PADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  column_zscore_normalizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // shadow of the block's state
  logic [31:0] zs_store [NROWS*NCOLS];
  logic [31:0] col_mean [NCOLS];
  logic [31:0] col_dev [NCOLS];
  int unsigned full_rows;
  int unsigned fill_col;
  bit stats_ok;
  logic [7:0] cols_reg;

  out_item_t zscore_q[$];
  int mismatches = 0;
  bit failed = 0;
  int beats_sent = 0;

  function automatic int unsigned eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > NCOLS) return NCOLS;
    return cols_reg;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] t;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  // column mean and population deviation over complete rows
  function automatic void column_stats();
    longint sum;
    longint mean;
    longint d;
    logic [63:0] m;
    logic [127:0] acc;
    logic [127:0] var_q;
    for (int c = 0; c < eff_cols(); c++) begin
      sum = 0;
      for (int r = 0; r < full_rows; r++) sum += longint'(signed'(zs_store[r*NCOLS+c]));
      mean = sum / longint'(full_rows);
      acc = 0;
      for (int r = 0; r < full_rows; r++) begin
        d = longint'(signed'(zs_store[r*NCOLS+c])) - mean;
        m = (d < 0) ? -d : d;
        acc += {64'd0, m} * {64'd0, m};
      end
      var_q = acc / full_rows;
      col_mean[c] = mean[31:0];
      col_dev[c] = 32'(isqrt(var_q[63:0]));
    end
    stats_ok = 1;
  endfunction

  function automatic out_item_t zscore_step(in_item_t it);
    out_item_t res;
    longint d;
    longint v;
    int unsigned cols;
    cols = eff_cols();
    res.value = 0;
    res.status = ST_OK;
    case (it.op)
      OP_LOAD: begin
        if (fill_col >= cols) begin
          fill_col = 0;
          if (full_rows < NROWS) full_rows++;
        end
        if (full_rows >= NROWS) begin
          res.status = ST_FULL;
        end else begin
          zs_store[full_rows*NCOLS+fill_col] = it.sample;
          fill_col++;
          if (fill_col >= cols) begin
            fill_col = 0;
            full_rows++;
          end
          stats_ok = 0;
        end
      end
      OP_COMPUTE: begin
        if (full_rows == 0) begin
          stats_ok = 0;
          res.status = ST_NO_STATS;
        end else begin
          column_stats();
        end
      end
      OP_READ: begin
        if (!stats_ok) res.status = ST_NO_STATS;
        else if (it.row_index >= full_rows || it.col_index >= cols) res.status = ST_BAD_INDEX;
        else if (col_dev[it.col_index] == 0) res.status = ST_ZERO_DEV;
        else begin
          d = longint'(signed'(zs_store[it.row_index*NCOLS+it.col_index]))
              - longint'(signed'(col_mean[it.col_index]));
          v = (d * 65536) / longint'({32'd0, col_dev[it.col_index]});
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          res.value = v[31:0];
        end
      end
      default: begin
        full_rows = 0;
        fill_col = 0;
        stats_ok = 0;
      end
    endcase
    return res;
  endfunction

  // result checking
  int stall_left = 0;
  bit out_burst = 0;
  int unsigned out_taken = 0;
  int unsigned out_seen = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (zscore_q.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: value %h status %0d",
                                       out_data.value, out_data.status);
      end else begin
        want = zscore_q.pop_front();
        if (out_data.value !== want.value || out_data.status !== want.status) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     want.value, want.status, out_data.value, out_data.status);
        end
      end
      out_taken++;
    end
  end

  // receiver back-pressure, a new wait drawn after every taken beat
  always @(negedge clk) begin
    if (out_seen != out_taken) begin
      out_seen = out_taken;
      if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
      stall_left = out_burst ? 0 : $urandom_range(0, 10);
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  bit in_burst;

  // one beat into the block; the task enters and leaves at a falling edge
  task automatic send_beat(in_item_t it, bit has_exp = 0, out_item_t exp_res = '0);
    int gap;
    out_item_t pred;
    if ($urandom_range(0, 31) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = zscore_step(it);
    zscore_q.push_back(has_exp ? exp_res : pred);
    beats_sent++;
    @(negedge clk);
  endtask

  // hold the sender until every beat has come back
  task automatic drain();
    in_valid = 1'b0;
    while (zscore_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_columns(logic [7:0] v);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = CFG_PADDR_W'(4 * CFG_IDX_COLUMNS);
    cfg_pwdata = {24'd0, v};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cols_reg = v;
    stats_ok = 0;
  endtask

  function automatic in_item_t mk(op_t op, logic [31:0] s = 0, int r = 0, int c = 0);
    in_item_t it;
    it.op = op;
    it.sample = s;
    it.row_index = r[9:0];
    it.col_index = c[6:0];
    return it;
  endfunction

  function automatic out_item_t res(logic [31:0] v, status_t s);
    out_item_t o;
    o.value = v;
    o.status = s;
    return o;
  endfunction

  // directed table: a row is either a register write or one command beat
  typedef struct {
    bit is_cfg;
    logic [7:0] cfg_val;
    in_item_t it;
    bit has_exp;
    out_item_t exp_res;
  } step_t;

  step_t steps[$];

  task automatic add(in_item_t it, bit has_exp = 0, out_item_t e = '0);
    steps.push_back('{0, 8'd0, it, has_exp, e});
  endtask

  task automatic add_cfg(logic [7:0] v);
    steps.push_back('{1, v, '0, 0, '0});
  endtask

  // a burst: complete rows, compute, then reads, some out of range or replaced by random commands
  task automatic rows_then_reads(int nrows, int nreads);
    int unsigned cols;
    cols = eff_cols();
    if (full_rows + nrows + 1 >= NROWS) send_beat(mk(OP_CLEAR));
    for (int i = 0; i < nrows * cols; i++) begin
      case ($urandom_range(0, 5))
        0: send_beat(mk(OP_LOAD, $urandom_range(0, 7) << 16));
        1: send_beat(mk(OP_LOAD, $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000));
        default: send_beat(mk(OP_LOAD, $urandom()));
      endcase
    end
    send_beat(mk(OP_COMPUTE));
    for (int i = 0; i < nreads; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_beat(mk(OP_READ, $urandom(), $urandom_range(0, 1023), $urandom_range(0, 127)));
      else if ($urandom_range(0, 15) == 0)
        send_beat(mk(op_t'($urandom_range(0, 3)), $urandom(),
                     $urandom_range(0, 1023), $urandom_range(0, 127)));
      else
        send_beat(mk(OP_READ, $urandom(), $urandom_range(0, full_rows - 1),
                     $urandom_range(0, cols - 1)));
    end
  endtask

  logic [7:0] settings[$] = '{8'd3, 8'd128, 8'd255, 8'd0, 8'd7, 8'd2, 8'd1, 8'd16};

  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_burst = 0;
    full_rows = 0;
    fill_col = 0;
    stats_ok = 0;
    cols_reg = COLUMNS_RST;
    foreach (col_mean[i]) begin
      col_mean[i] = 0;
      col_dev[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part
    add(mk(OP_READ), 1, res(0, ST_NO_STATS));
    add(mk(OP_COMPUTE), 1, res(0, ST_NO_STATS));
    add(mk(OP_LOAD, 32'h7fffffff), 1, res(0, ST_OK));
    add(mk(OP_LOAD, 32'h80000000));
    add(mk(OP_LOAD, 32'h0));
    add(mk(OP_COMPUTE));
    add(mk(OP_READ, 0, 0, 0));
    add(mk(OP_READ, 0, 3, 0), 1, res(0, ST_BAD_INDEX));
    add(mk(OP_READ, 0, 0, 1), 1, res(0, ST_BAD_INDEX));
    add(mk(OP_CLEAR), 1, res(0, ST_OK));
    add(mk(OP_LOAD, 32'h5));
    add(mk(OP_LOAD, 32'h5));
    add(mk(OP_COMPUTE));
    add(mk(OP_READ, 0, 1, 0), 1, res(0, ST_ZERO_DEV));
    add(mk(OP_CLEAR));
    add_cfg(8'd4);
    add(mk(OP_LOAD, 32'hfffe0000));
    add(mk(OP_LOAD, 32'h00030000));
    add(mk(OP_LOAD, 32'h12345678));
    // shrinking mid-row closes the partial row on the next load
    add_cfg(8'd2);
    add(mk(OP_LOAD, 32'h00010000));
    add(mk(OP_LOAD, 32'h80000001));
    add(mk(OP_COMPUTE));
    add(mk(OP_READ, 0, 0, 1));
    add(mk(OP_READ, 0, 1, 0));
    add(mk(OP_READ, 0, 1023, 127), 1, res(0, ST_BAD_INDEX));
    add(mk(OP_CLEAR));
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        drain();
        write_columns(steps[i].cfg_val);
      end else begin
        send_beat(steps[i].it, steps[i].has_exp, steps[i].exp_res);
      end
    end

    // random part, one block per column setting
    foreach (settings[k]) begin
      drain();
      send_beat(mk(OP_CLEAR));
      drain();
      write_columns(settings[k]);
      sent = beats_sent;
      while (beats_sent - sent < 25) begin
        if (eff_cols() > 32) begin
          rows_then_reads(1, 15);
        end else begin
          rows_then_reads($urandom_range(1, 6), $urandom_range(4, 12));
        end
        if ($urandom_range(0, 3) == 0) send_beat(mk(OP_CLEAR));
      end
    end

    drain();
    repeat (50) @(negedge clk);
    if (!failed && zscore_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #80_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
hw/rtl/czn_pkg.sv
hw/rtl/czn_ram.sv
hw/rtl/czn_div.sv
hw/rtl/czn_ctrl.sv
hw/rtl/czn_dp.sv
hw/rtl/column_zscore_normalizer.sv
verif/tb.sv
